@@ rtl/core/prb_pkg.sv @@
// Shared types and constants for the packet resequencing buffer.
package prb_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int SEQ_W = 32;
   localparam int LEN_W = 16;
   localparam int TAG_W = 32;
   localparam int DATA_W = SEQ_W + LEN_W + TAG_W;

   typedef enum logic [1:0] {
      STATUS_DELIVERED = 2'd0,
      STATUS_FLUSHED   = 2'd1,
      STATUS_DROPPED   = 2'd2
   } status_type;

   typedef enum logic {
      KIND_ARRIVAL = 1'b0,
      KIND_FLUSH   = 1'b1
   } kind_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [LEN_W-1:0] len;
      logic [SEQ_W-1:0] seq;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic shift;
      logic rotate;
   } cell_ctrl_type;

endpackage

@@ rtl/core/prb_cell.sv @@
// One slot of the sorted descriptor chain.
module prb_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  prb_pkg::cell_ctrl_type ctrl,
   input  prb_pkg::entry_type     new_entry,
   input  prb_pkg::entry_type     left_entry,
   input  logic                   left_valid,
   input  logic                   left_gt,
   input  prb_pkg::entry_type     right_entry,
   input  logic                   right_valid,
   input  prb_pkg::entry_type     wrap_entry,
   output prb_pkg::entry_type     entry,
   output logic                   valid,
   output logic                   gt
);

   prb_pkg::entry_type entry_ff;
   logic               valid_ff;

   assign entry = entry_ff;
   assign valid = valid_ff;
   assign gt    = valid_ff && (entry_ff.seq > new_entry.seq);

   always_ff @(posedge clock) begin
      if (ctrl.insert) begin
         if (left_gt) begin
            entry_ff <= left_entry;
         end else if (left_valid && (gt || !valid_ff)) begin
            entry_ff <= new_entry;
         end
      end else if (ctrl.shift) begin
         entry_ff <= right_entry;
      end else if (ctrl.rotate && valid_ff) begin
         entry_ff <= right_valid ? right_entry : wrap_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.insert) begin
         valid_ff <= valid_ff || left_valid;
      end else if (ctrl.shift) begin
         valid_ff <= right_valid;
      end
   end

endmodule

@@ rtl/core/packet_resequencing_buffer.sv @@
// Top level: sorted cell chain, delivery/flush sequencer and output word register.
// Arrival: inserted into the chain, then ST_DELIVER emits each in-order delivery;
// an arrival with nothing deliverable goes back to idle. Drop on full: one word.
// Flush: one word per held entry (chain rotates once per word).
// A stalled output word holds the sequencer and the input.
// Reset (synchronous): chain empty, expected sequence = 0, no word pending.
module packet_resequencing_buffer #(
   parameter int CAPACITY = prb_pkg::CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [prb_pkg::DATA_W-1:0] req_tdata,  // packet_seq, packet_length, payload_tag
   input  logic                      req_tuser,  // kind
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [prb_pkg::DATA_W-1:0] rsp_tdata,  // out_seq, out_length, out_tag
   output logic [1:0]                rsp_tuser,  // status
   output logic                      rsp_tlast,
   input  logic                      csr_we,
   input  logic [prb_pkg::SEQ_W-1:0] csr_wdata
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_CNT = CW'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DELIVER,
      ST_FLUSH
   } state_type;

   state_type                   state_ff;
   logic [CW-1:0]               count_ff;
   logic [CW-1:0]               rem_ff;
   logic [prb_pkg::SEQ_W-1:0]   expected_ff;
   logic [prb_pkg::SEQ_W-1:0]   expected_in;
   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_status_ff;
   prb_pkg::entry_type          rsp_entry_ff;
   logic                        rsp_last_ff;

   prb_pkg::entry_type          cell_entry [CAPACITY];
   logic [CAPACITY-1:0]         cell_valid;
   logic [CAPACITY-1:0]         cell_gt;
   prb_pkg::cell_ctrl_type      ctrl;
   prb_pkg::entry_type          req_entry;

   logic out_free;
   logic req_accept;
   logic full;
   logic head_match;
   logic next_match;
   logic rsp_load;

   assign req_entry  = prb_pkg::entry_type'(req_tdata);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_accept = req_tvalid && req_tready;
   assign full       = (count_ff == CAP_CNT);
   assign expected_in = expected_ff + 32'd1;
   assign head_match = cell_valid[0] && (cell_entry[0].seq == expected_ff);
   assign next_match = cell_valid[1] && (cell_entry[1].seq == expected_in);

   assign ctrl.insert = req_accept && (req_tuser == prb_pkg::KIND_ARRIVAL) && !full;
   assign ctrl.shift  = (state_ff == ST_DELIVER) && head_match && out_free;
   assign ctrl.rotate = (state_ff == ST_FLUSH) && out_free;

   // a new word enters the output register this cycle
   assign rsp_load = (req_accept && (req_tuser == prb_pkg::KIND_ARRIVAL) && full) ||
                     ctrl.shift || ctrl.rotate;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      prb_pkg::entry_type l_entry;
      logic               l_valid;
      logic               l_gt;
      prb_pkg::entry_type r_entry;
      logic               r_valid;

      if (i == 0) begin : g_first
         assign l_entry = req_entry;
         assign l_valid = 1'b1;
         assign l_gt    = 1'b0;
      end else begin : g_mid
         assign l_entry = cell_entry[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_gt    = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign r_entry = cell_entry[0];
         assign r_valid = 1'b0;
      end else begin : g_inner
         assign r_entry = cell_entry[i+1];
         assign r_valid = cell_valid[i+1];
      end

      prb_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_entry   (req_entry),
         .left_entry  (l_entry),
         .left_valid  (l_valid),
         .left_gt     (l_gt),
         .right_entry (r_entry),
         .right_valid (r_valid),
         .wrap_entry  (cell_entry[0]),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i]),
         .gt          (cell_gt[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         expected_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            expected_ff <= csr_wdata;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_tuser == prb_pkg::KIND_FLUSH) begin
                     if (count_ff != '0) begin
                        rem_ff   <= count_ff;
                        state_ff <= ST_FLUSH;
                     end
                  end else if (full) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= prb_pkg::STATUS_DROPPED;
                     rsp_entry_ff  <= req_entry;
                     rsp_last_ff   <= 1'b1;
                  end else begin
                     count_ff <= count_ff + ONE_CNT;
                     state_ff <= ST_DELIVER;
                  end
               end
            end
            ST_DELIVER: begin
               if (!head_match) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= prb_pkg::STATUS_DELIVERED;
                  rsp_entry_ff  <= cell_entry[0];
                  rsp_last_ff   <= !next_match;
                  expected_ff   <= expected_in;
                  count_ff      <= count_ff - ONE_CNT;
                  if (!next_match) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_FLUSH: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= prb_pkg::STATUS_FLUSHED;
                  rsp_entry_ff  <= cell_entry[0];
                  rsp_last_ff   <= (rem_ff == ONE_CNT);
                  rem_ff        <= rem_ff - ONE_CNT;
                  if (rem_ff == ONE_CNT) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_entry_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == 32'(count_ff))
      else $error("cell valid bits disagree with entry count");

   a_drop_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == prb_pkg::STATUS_DROPPED) |-> rsp_last_ff)
      else $error("drop word without last");

   a_flush_keeps_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |=> $stable(count_ff))
      else $error("flush changed entry count");

endmodule
